FILE: design/ectf_pkg.sv
`default_nettype none

package ectf_pkg;

  // Field widths.
  localparam int unsigned EnergyWidth = 24;
  localparam int unsigned NoiseWidth  = 20;
  localparam int unsigned TimeWidth   = 16;
  localparam int unsigned EtaWidth    = 14;
  localparam int unsigned ProvWidth   = 16;
  localparam int unsigned CountWidth  = 16;
  localparam int unsigned EsumWidth   = 40;
  localparam int unsigned TsumWidth   = 32;
  localparam int unsigned AddrWidth   = 4;
  localparam int unsigned DataWidth   = 32;

  // A side's count stops here; further kept cells on that side are dropped.
  localparam logic [CountWidth-1:0] MaxCells = 16'hFFFF;

  // The mean is found one quotient bit per cycle over the time-sum magnitude.
  localparam int unsigned DivSteps    = TsumWidth;
  localparam int unsigned DivCntWidth = $clog2(DivSteps);

  // |eta| >= 1.5 in 1/1024 units.
  localparam logic signed [EtaWidth-1:0] EtaMinPos = 14'sd1536;
  localparam logic signed [EtaWidth-1:0] EtaMinNeg = -14'sd1536;

  // Energy cuts per region in MeV.
  localparam logic signed [EnergyWidth-1:0] EcutFwd0        = 24'sd1200;
  localparam logic signed [EnergyWidth-1:0] EcutInnerWheel  = 24'sd250;

  // Provenance tests.
  localparam logic [ProvWidth-1:0] ProvMaskIter   = 16'h3DFF;
  localparam logic [ProvWidth-1:0] ProvMaskPlain  = 16'h3CFF;
  localparam logic [ProvWidth-1:0] ProvPatIter    = 16'h21A5;
  localparam logic [ProvWidth-1:0] ProvPatPlain   = 16'h20A5;
  localparam logic [ProvWidth-1:0] ProvAltMask    = 16'h3C00;
  localparam logic [ProvWidth-1:0] ProvAltPattern = 16'h3000;
  localparam logic [ProvWidth-1:0] ProvSimMask    = 16'h2C00;
  localparam logic [ProvWidth-1:0] ProvSimPattern = 16'h2000;

  // Reset values of the configuration registers.
  localparam logic                  IterCheckReset  = 1'b1;
  localparam logic                  SimDataReset    = 1'b0;
  localparam logic [CountWidth-1:0] MinCountReset   = 16'd2;
  localparam logic [TimeWidth-1:0]  TimeWindowReset = 16'd160;

  typedef enum logic [1:0] {
    RegionOther      = 2'd0,
    RegionTile       = 2'd1,
    RegionFwd0       = 2'd2,
    RegionInnerWheel = 2'd3
  } region_e;

  typedef enum logic [1:0] {
    RegIterCheck  = 2'd0,
    RegSimData    = 2'd1,
    RegMinCount   = 2'd2,
    RegTimeWindow = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic accept;       // a cell transaction completes this cycle
    logic div_start;    // load the divider
    logic div_side_c;   // divider operands come from side C
    logic cap_a;        // capture the side A mean
    logic cap_c;        // capture the side C mean
    logic load_result;  // fill the output register and clear the sums
  } ectf_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
  } ectf_sts_t;

endpackage

`default_nettype wire

FILE: design/ectf_div.sv
`default_nettype none

module ectf_div (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      start_i,
  input  wire logic signed [ectf_pkg::TsumWidth-1:0]     dividend_i,
  input  wire logic        [ectf_pkg::CountWidth-1:0]    divisor_i,
  output logic                                           busy_o,
  output logic                                           done_o,
  output logic signed [ectf_pkg::TimeWidth-1:0]          quotient_o
);

  logic                                  busy_q, busy_d;
  logic                                  done_q, done_d;
  logic [ectf_pkg::DivCntWidth-1:0]      cnt_q, cnt_d;
  logic                                  neg_q, neg_d;
  logic [ectf_pkg::CountWidth-1:0]       dvr_q, dvr_d;
  logic [ectf_pkg::CountWidth-1:0]       rem_q, rem_d;
  logic [ectf_pkg::TsumWidth-1:0]        quo_q, quo_d;
  logic [ectf_pkg::CountWidth:0]         shifted;
  logic [ectf_pkg::CountWidth:0]         trial;
  logic                                  fits;
  logic [ectf_pkg::TsumWidth-1:0]        quo_signed;

  assign shifted = {rem_q, quo_q[ectf_pkg::TsumWidth-1]};
  assign trial   = shifted - {1'b0, dvr_q};
  assign fits    = (shifted >= {1'b0, dvr_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    dvr_d  = dvr_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      neg_d  = dividend_i[ectf_pkg::TsumWidth-1];
      dvr_d  = divisor_i;
      rem_d  = '0;
      quo_d  = dividend_i[ectf_pkg::TsumWidth-1] ? (~dividend_i + 1'b1) : dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? trial[ectf_pkg::CountWidth-1:0] : shifted[ectf_pkg::CountWidth-1:0];
      quo_d = {quo_q[ectf_pkg::TsumWidth-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == ectf_pkg::DivCntWidth'(ectf_pkg::DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    dvr_q <= dvr_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  // The quotient magnitude never exceeds 32768, so the low bits carry the mean.
  assign quo_signed = neg_q ? (~quo_q + 1'b1) : quo_q;
  assign quotient_o = quo_signed[ectf_pkg::TimeWidth-1:0];
  assign busy_o     = busy_q;
  assign done_o     = done_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider reports done while still iterating");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a preceding iteration");

endmodule

`default_nettype wire

FILE: design/ectf_ctrl.sv
`default_nettype none

module ectf_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              last_cell_i,
  output logic                   in_ready_o,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  input  wire ectf_pkg::ectf_sts_t sts_i,
  output ectf_pkg::ectf_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_START_A = 6'b000010,
    S_WAIT_A  = 6'b000100,
    S_START_C = 6'b001000,
    S_WAIT_C  = 6'b010000,
    S_LOAD    = 6'b100000
  } ectf_state_e;

  ectf_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        accept;
  logic        out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.accept = accept;
    case (state_q)
      S_IDLE: begin
        if (accept && last_cell_i) begin
          state_d = S_START_A;
        end
      end
      S_START_A: begin
        cmd_o.div_start = 1'b1;
        state_d = S_WAIT_A;
      end
      S_WAIT_A: begin
        if (sts_i.div_done) begin
          cmd_o.cap_a = 1'b1;
          state_d = S_START_C;
        end
      end
      S_START_C: begin
        cmd_o.div_start  = 1'b1;
        cmd_o.div_side_c = 1'b1;
        state_d = S_WAIT_C;
      end
      S_WAIT_C: begin
        if (sts_i.div_done) begin
          cmd_o.cap_c = 1'b1;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        if (out_free) begin
          cmd_o.load_result = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_result) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !sts_i.div_busy)
    else $error("divider started while busy");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == S_WAIT_A || state_q == S_WAIT_C))
    else $error("divider finished outside a wait state");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_result |=> out_valid_q && state_q == S_IDLE)
    else $error("result load did not raise the output valid");

endmodule

`default_nettype wire

FILE: design/ectf_dp.sv
`default_nettype none

module ectf_dp (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire ectf_pkg::ectf_cmd_t                        cmd_i,
  output ectf_pkg::ectf_sts_t                             sts_o,
  input  wire logic                                       iter_check_i,
  input  wire logic                                       sim_data_i,
  input  wire logic        [ectf_pkg::CountWidth-1:0]     min_count_i,
  input  wire logic        [ectf_pkg::TimeWidth-1:0]      time_window_i,
  input  wire logic signed [ectf_pkg::EnergyWidth-1:0]    cell_energy_i,
  input  wire logic        [ectf_pkg::NoiseWidth-1:0]     cell_noise_i,
  input  wire logic signed [ectf_pkg::TimeWidth-1:0]      cell_time_i,
  input  wire logic signed [ectf_pkg::EtaWidth-1:0]       cell_eta_i,
  input  wire logic        [ectf_pkg::ProvWidth-1:0]      provenance_word_i,
  input  wire logic        [1:0]                          cell_region_i,
  output logic                                            event_passed_o,
  output logic        [ectf_pkg::CountWidth-1:0]          count_side_a_o,
  output logic        [ectf_pkg::CountWidth-1:0]          count_side_c_o,
  output logic signed [ectf_pkg::EsumWidth-1:0]           energy_side_a_o,
  output logic signed [ectf_pkg::EsumWidth-1:0]           energy_side_c_o,
  output logic signed [ectf_pkg::TimeWidth-1:0]           mean_time_a_o,
  output logic signed [ectf_pkg::TimeWidth-1:0]           mean_time_c_o
);

  // Cell selection.
  logic                                   is_tile;
  logic                                   eta_ok;
  logic [ectf_pkg::ProvWidth-1:0]         data_mask;
  logic [ectf_pkg::ProvWidth-1:0]         data_pat;
  logic                                   prov_ok;
  logic [ectf_pkg::NoiseWidth+2:0]        noise5;
  logic signed [ectf_pkg::EnergyWidth:0]  energy_ext;
  logic signed [ectf_pkg::EnergyWidth:0]  noise5_ext;
  logic                                   sig_ok;
  logic                                   cut_ok;
  logic                                   keep;
  logic                                   side_a;
  logic                                   add_a;
  logic                                   add_c;

  assign is_tile = (cell_region_i == ectf_pkg::RegionTile);
  assign eta_ok  = (cell_eta_i >= ectf_pkg::EtaMinPos) || (cell_eta_i <= ectf_pkg::EtaMinNeg);

  assign data_mask = iter_check_i ? ectf_pkg::ProvMaskIter : ectf_pkg::ProvMaskPlain;
  assign data_pat  = iter_check_i ? ectf_pkg::ProvPatIter : ectf_pkg::ProvPatPlain;
  assign prov_ok   = sim_data_i
                   ? ((provenance_word_i & ectf_pkg::ProvSimMask) == ectf_pkg::ProvSimPattern)
                   : (((provenance_word_i & data_mask) == data_pat) ||
                      ((provenance_word_i & ectf_pkg::ProvAltMask) == ectf_pkg::ProvAltPattern));

  // Five times the noise as a shift and an add.
  assign noise5     = {1'b0, cell_noise_i, 2'b00} + {3'b000, cell_noise_i};
  assign energy_ext = {cell_energy_i[ectf_pkg::EnergyWidth-1], cell_energy_i};
  assign noise5_ext = {2'b00, noise5};
  assign sig_ok     = (cell_noise_i == '0) || (energy_ext >= noise5_ext);

  always_comb begin
    cut_ok = 1'b0;
    if (cell_region_i == ectf_pkg::RegionFwd0) begin
      cut_ok = (cell_energy_i >= ectf_pkg::EcutFwd0);
    end else if (cell_region_i == ectf_pkg::RegionInnerWheel) begin
      cut_ok = (cell_energy_i >= ectf_pkg::EcutInnerWheel);
    end
  end

  assign keep   = !is_tile && eta_ok && prov_ok && sig_ok && cut_ok;
  assign side_a = (cell_eta_i > $signed({ectf_pkg::EtaWidth{1'b0}}));

  // Accumulators.
  logic        [ectf_pkg::CountWidth-1:0] kept_a_q, kept_a_d, kept_c_q, kept_c_d;
  logic signed [ectf_pkg::EsumWidth-1:0]  esum_a_q, esum_a_d, esum_c_q, esum_c_d;
  logic signed [ectf_pkg::TsumWidth-1:0]  tsum_a_q, tsum_a_d, tsum_c_q, tsum_c_d;
  logic signed [ectf_pkg::EsumWidth-1:0]  energy_wide;
  logic signed [ectf_pkg::TsumWidth-1:0]  time_wide;

  assign energy_wide = {{(ectf_pkg::EsumWidth-ectf_pkg::EnergyWidth){cell_energy_i[ectf_pkg::EnergyWidth-1]}},
                        cell_energy_i};
  assign time_wide   = {{(ectf_pkg::TsumWidth-ectf_pkg::TimeWidth){cell_time_i[ectf_pkg::TimeWidth-1]}},
                        cell_time_i};

  assign add_a = cmd_i.accept && keep && side_a && (kept_a_q != ectf_pkg::MaxCells);
  assign add_c = cmd_i.accept && keep && !side_a && (kept_c_q != ectf_pkg::MaxCells);

  always_comb begin
    kept_a_d = kept_a_q;
    kept_c_d = kept_c_q;
    esum_a_d = esum_a_q;
    esum_c_d = esum_c_q;
    tsum_a_d = tsum_a_q;
    tsum_c_d = tsum_c_q;
    if (cmd_i.load_result) begin
      kept_a_d = '0;
      kept_c_d = '0;
      esum_a_d = '0;
      esum_c_d = '0;
      tsum_a_d = '0;
      tsum_c_d = '0;
    end else begin
      if (add_a) begin
        kept_a_d = kept_a_q + 1'b1;
        esum_a_d = esum_a_q + energy_wide;
        tsum_a_d = tsum_a_q + time_wide;
      end
      if (add_c) begin
        kept_c_d = kept_c_q + 1'b1;
        esum_c_d = esum_c_q + energy_wide;
        tsum_c_d = tsum_c_q + time_wide;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_a_q <= '0;
      kept_c_q <= '0;
      esum_a_q <= '0;
      esum_c_q <= '0;
      tsum_a_q <= '0;
      tsum_c_q <= '0;
    end else begin
      kept_a_q <= kept_a_d;
      kept_c_q <= kept_c_d;
      esum_a_q <= esum_a_d;
      esum_c_q <= esum_c_d;
      tsum_a_q <= tsum_a_d;
      tsum_c_q <= tsum_c_d;
    end
  end

  // Shared divider for the two side means.
  logic signed [ectf_pkg::TimeWidth-1:0] quotient;
  logic                                  div_busy;
  logic                                  div_done;

  ectf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (cmd_i.div_side_c ? tsum_c_q : tsum_a_q),
    .divisor_i  (cmd_i.div_side_c ? kept_c_q : kept_a_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign sts_o.div_busy = div_busy;
  assign sts_o.div_done = div_done;

  logic signed [ectf_pkg::TimeWidth-1:0] mean_a_q, mean_c_q;

  // An empty side has a mean of zero.
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_a) begin
      mean_a_q <= (kept_a_q == '0) ? '0 : quotient;
    end
    if (cmd_i.cap_c) begin
      mean_c_q <= (kept_c_q == '0) ? '0 : quotient;
    end
  end

  // Event decision.
  logic signed [ectf_pkg::TimeWidth:0] mean_diff;
  logic        [ectf_pkg::TimeWidth:0] mean_dist;
  logic                                passed;

  assign mean_diff = {mean_a_q[ectf_pkg::TimeWidth-1], mean_a_q}
                   - {mean_c_q[ectf_pkg::TimeWidth-1], mean_c_q};
  assign mean_dist = mean_diff[ectf_pkg::TimeWidth] ? (~mean_diff + 1'b1) : mean_diff;
  assign passed    = (kept_a_q > min_count_i) && (kept_c_q > min_count_i) &&
                     (mean_dist < {1'b0, time_window_i});

  // Output register.
  logic                                   passed_q;
  logic        [ectf_pkg::CountWidth-1:0] res_kept_a_q, res_kept_c_q;
  logic signed [ectf_pkg::EsumWidth-1:0]  res_esum_a_q, res_esum_c_q;
  logic signed [ectf_pkg::TimeWidth-1:0]  res_mean_a_q, res_mean_c_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      passed_q     <= passed;
      res_kept_a_q <= kept_a_q;
      res_kept_c_q <= kept_c_q;
      res_esum_a_q <= esum_a_q;
      res_esum_c_q <= esum_c_q;
      res_mean_a_q <= mean_a_q;
      res_mean_c_q <= mean_c_q;
    end
  end

  assign event_passed_o  = passed_q;
  assign count_side_a_o  = res_kept_a_q;
  assign count_side_c_o  = res_kept_c_q;
  assign energy_side_a_o = res_esum_a_q;
  assign energy_side_c_o = res_esum_c_q;
  assign mean_time_a_o   = res_mean_a_q;
  assign mean_time_c_o   = res_mean_c_q;

  a_no_add_during_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_result |-> !cmd_i.accept)
    else $error("cell accepted while the result is being loaded");

  a_clear_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_result |=> kept_a_q == '0 && kept_c_q == '0)
    else $error("counts not cleared after the result load");

endmodule

`default_nettype wire

FILE: design/endcap_collision_time_filter.sv
`default_nettype none

// Endcap collision time filter. Cells enter one transaction at a time on the
// in channel; a cell is kept when it is not a tile cell, its |eta| is at
// least 1.5, its provenance word passes the data or simulation test, its
// energy is at least five times a positive noise, and its region energy cut
// is met (1200 MeV forward layer 0, 250 MeV endcap inner wheel). Kept cells
// add to a per-side count, energy sum and time sum, with side A for positive
// eta and side C otherwise; a side that reaches 65535 cells ignores further
// cells. Ordinary cells are taken at one per cycle. The cell marked last
// ends the event: the block then stops taking cells while one shared
// restoring divider finds each side mean in turn, one quotient bit per
// cycle, before the result transaction is placed in the output register
// and the sums are cleared. That pause grows by as long as
// the previous result still waits on the out channel. Cells of the next
// event are taken while a result waits on the out channel. The four
// configuration registers sit on the APB port at byte addresses 0, 4, 8 and
// 12 and should be written only while no event is in flight.

module endcap_collision_time_filter (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  // Configuration port.
  input  wire logic                                     psel,
  input  wire logic                                     penable,
  input  wire logic                                     pwrite,
  input  wire logic        [ectf_pkg::AddrWidth-1:0]    paddr,
  input  wire logic        [ectf_pkg::DataWidth-1:0]    pwdata,
  output logic             [ectf_pkg::DataWidth-1:0]    prdata,
  output logic                                          pready,
  // Cell channel.
  input  wire logic                                     in_valid_i,
  output logic                                          in_ready_o,
  input  wire logic signed [ectf_pkg::EnergyWidth-1:0]  cell_energy_i,
  input  wire logic        [ectf_pkg::NoiseWidth-1:0]   cell_noise_i,
  input  wire logic signed [ectf_pkg::TimeWidth-1:0]    cell_time_i,
  input  wire logic signed [ectf_pkg::EtaWidth-1:0]     cell_eta_i,
  input  wire logic        [ectf_pkg::ProvWidth-1:0]    provenance_word_i,
  input  wire logic        [1:0]                        cell_region_i,
  input  wire logic                                     last_cell_i,
  // Event result channel.
  output logic                                          out_valid_o,
  input  wire logic                                     out_ready_i,
  output logic                                          event_passed_o,
  output logic             [ectf_pkg::CountWidth-1:0]   count_side_a_o,
  output logic             [ectf_pkg::CountWidth-1:0]   count_side_c_o,
  output logic signed      [ectf_pkg::EsumWidth-1:0]    energy_side_a_o,
  output logic signed      [ectf_pkg::EsumWidth-1:0]    energy_side_c_o,
  output logic signed      [ectf_pkg::TimeWidth-1:0]    mean_time_a_o,
  output logic signed      [ectf_pkg::TimeWidth-1:0]    mean_time_c_o
);

  // The configuration registers. A write lands in the access phase; the
  // port never inserts wait states.
  logic                              iter_check_q;
  logic                              sim_data_q;
  logic [ectf_pkg::CountWidth-1:0]   min_count_q;
  logic [ectf_pkg::TimeWidth-1:0]    time_window_q;
  logic                              cfg_write;
  logic [1:0]                        reg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = paddr[ectf_pkg::AddrWidth-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_check_q  <= ectf_pkg::IterCheckReset;
      sim_data_q    <= ectf_pkg::SimDataReset;
      min_count_q   <= ectf_pkg::MinCountReset;
      time_window_q <= ectf_pkg::TimeWindowReset;
    end else if (cfg_write) begin
      case (reg_idx)
        ectf_pkg::RegIterCheck:  iter_check_q  <= pwdata[0];
        ectf_pkg::RegSimData:    sim_data_q    <= pwdata[0];
        ectf_pkg::RegMinCount:   min_count_q   <= pwdata[ectf_pkg::CountWidth-1:0];
        ectf_pkg::RegTimeWindow: time_window_q <= pwdata[ectf_pkg::TimeWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read data is zero-extended into the 32-bit bus.
  always_comb begin
    case (reg_idx)
      ectf_pkg::RegIterCheck:  prdata = {{(ectf_pkg::DataWidth-1){1'b0}}, iter_check_q};
      ectf_pkg::RegSimData:    prdata = {{(ectf_pkg::DataWidth-1){1'b0}}, sim_data_q};
      ectf_pkg::RegMinCount:
        prdata = {{(ectf_pkg::DataWidth-ectf_pkg::CountWidth){1'b0}}, min_count_q};
      ectf_pkg::RegTimeWindow:
        prdata = {{(ectf_pkg::DataWidth-ectf_pkg::TimeWidth){1'b0}}, time_window_q};
      default: prdata = '0;
    endcase
  end

  // The controller sequences the event end; the datapath filters cells,
  // accumulates the side sums and holds the result transaction.
  ectf_pkg::ectf_cmd_t cmd;
  ectf_pkg::ectf_sts_t sts;

  ectf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_cell_i (last_cell_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ectf_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .iter_check_i      (iter_check_q),
    .sim_data_i        (sim_data_q),
    .min_count_i       (min_count_q),
    .time_window_i     (time_window_q),
    .cell_energy_i     (cell_energy_i),
    .cell_noise_i      (cell_noise_i),
    .cell_time_i       (cell_time_i),
    .cell_eta_i        (cell_eta_i),
    .provenance_word_i (provenance_word_i),
    .cell_region_i     (cell_region_i),
    .event_passed_o    (event_passed_o),
    .count_side_a_o    (count_side_a_o),
    .count_side_c_o    (count_side_c_o),
    .energy_side_a_o   (energy_side_a_o),
    .energy_side_c_o   (energy_side_c_o),
    .mean_time_a_o     (mean_time_a_o),
    .mean_time_c_o     (mean_time_c_o)
  );

endmodule

`default_nettype wire
